@@ rtl/mmra_pkg.sv @@
`default_nettype none
package mmra_pkg;

    localparam int SAMPLE_W = 32;
    localparam int CHAN_W   = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 31;

    localparam logic [CFG_IDX_W-1:0] CFG_AVG_TYPE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRE_OP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ALPHA      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_CRITERION  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_WATCHED    = 3'd5;

    localparam logic [1:0] AVG_CUM = 2'd0;
    localparam logic [1:0] AVG_WIN = 2'd1;
    localparam logic [1:0] AVG_EXP = 2'd2;

    localparam logic [1:0] PRE_PASS = 2'd0;
    localparam logic [1:0] PRE_ABS  = 2'd1;
    localparam logic [1:0] PRE_SQ   = 2'd2;

    localparam logic [16:0] ALPHA_ONE = 17'd65536;
    localparam logic [6:0]  WLEN_RESET  = 7'd8;
    localparam logic [16:0] ALPHA_RESET = 17'd3277;

    localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

@@ rtl/mmra_if.sv @@
`default_nettype none
interface mmra_in_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mmra_pkg::SAMPLE_W-1:0] sample;
    logic [mmra_pkg::CHAN_W-1:0]          channel;
    logic                                 end_of_tick;
    modport source (output valid, sample, channel, end_of_tick, input ready);
    modport sink   (input valid, sample, channel, end_of_tick, output ready);
endinterface

interface mmra_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mmra_pkg::SAMPLE_W-1:0] average;
    logic [mmra_pkg::CHAN_W-1:0]          out_channel;
    logic                                 terminate;
    modport source (output valid, average, out_channel, terminate, input ready);
    modport sink   (input valid, average, out_channel, terminate, output ready);
endinterface

interface mmra_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mmra_pkg::CFG_IDX_W-1:0]     index;
    logic [mmra_pkg::CFG_DATA_W-1:0]    data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ rtl/mmra_ram.sv @@
`default_nettype none
module mmra_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_we,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                 i_wdata,
    input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                 o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

@@ rtl/mmra_div.sv @@
`default_nettype none
module mmra_div (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic signed [63:0] i_dividend,
    input  wire logic [32:0]        i_divisor,
    output logic                    o_done,
    output logic signed [31:0]      o_quot
);
    logic        r_busy;
    logic [6:0]  r_cnt;
    logic [33:0] r_rem;
    logic [63:0] r_q;
    logic [32:0] r_d;
    logic        r_neg;
    logic [34:0] trial;
    logic        fits;

    assign trial = {r_rem[33:0], r_q[63]};
    assign fits  = trial >= {2'b00, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_rem  <= '0;
                r_neg  <= i_dividend[63];
                r_q    <= i_dividend[63] ? 64'(-i_dividend) : 64'(i_dividend);
                r_d    <= i_divisor;
            end else if (r_busy) begin
                r_rem <= fits ? 34'(trial - {2'b00, r_d}) : trial[33:0];
                r_q   <= {r_q[62:0], fits};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        if (r_neg) begin
            o_quot = (r_q > 64'h8000_0000) ? mmra_pkg::S32_MIN : 32'(-r_q[31:0]);
        end else begin
            o_quot = (r_q > 64'h7FFF_FFFF) ? mmra_pkg::S32_MAX : $signed(r_q[31:0]);
        end
    end
endmodule
`default_nettype wire

@@ rtl/multi_mode_running_average_unit.sv @@
`default_nettype none
// Channel  Dir  Handshake     Payload
// i_in     in   valid/ready   sample, channel, end_of_tick
// o_out    out  valid/ready   average, out_channel, terminate
// i_cfg    in   valid/ready   index, data (always ready)
//
// Cumulative and window means are computed by the one-bit-per-cycle 64-step
// divider; exponential average uses the one shared 33x33 multiplier. Input is
// held not ready while an item is in work. After reset, and after each change
// of window length, a clearing pass zeroes all WINDOW_MAX*CHANNELS words of
// the window store. A result waiting on o_out stalls only the end of the next
// item.
module multi_mode_running_average_unit #(
    parameter int CHANNELS   = 16,
    parameter int WINDOW_MAX = 64
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    mmra_in_if.sink     i_in,
    mmra_out_if.source  o_out,
    mmra_cfg_if.sink    i_cfg
);
    localparam int CW    = CHANNELS > 1 ? $clog2(CHANNELS) : 1;
    localparam int SW    = WINDOW_MAX > 1 ? $clog2(WINDOW_MAX) : 1;
    localparam int LW    = $clog2(WINDOW_MAX + 1) > 7 ? $clog2(WINDOW_MAX + 1) : 7;
    localparam int DEPTH = WINDOW_MAX * CHANNELS;
    localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_SQ, S_COND, S_DIV, S_EM1, S_EM2, S_EM3, S_TERM
    } t_state;

    t_state r_state;

    logic [1:0]  r_avg_type;
    logic [1:0]  r_pre_op;
    logic [6:0]  r_wlen;
    logic [16:0] r_alpha;
    logic [30:0] r_crit;
    logic [3:0]  r_watch;

    logic signed [63:0] r_cum  [CHANNELS];
    logic signed [39:0] r_wsum [CHANNELS];
    logic signed [31:0] r_last [CHANNELS];
    logic [31:0]        r_tick;
    logic [SW-1:0]      r_slot;

    logic               r_clr;
    logic [AW-1:0]      r_clr_addr;

    logic signed [31:0] r_sample;
    logic signed [31:0] r_x;
    logic [3:0]         r_ch;
    logic               r_eot;
    logic               r_in_rng;
    logic [AW-1:0]      r_widx;
    logic signed [32:0] r_ma;
    logic signed [32:0] r_mb;
    logic signed [65:0] r_prod;
    logic signed [49:0] r_acc;
    logic               r_div_go;

    logic               r_ovalid;
    logic signed [31:0] r_avg;
    logic signed [31:0] r_oavg;
    logic [3:0]         r_och;
    logic               r_term_done;

    logic [LW-1:0]      len;
    logic [LW-1:0]      slot_eff;
    logic [LW-1:0]      slot_inc;
    logic [CW-1:0]      chi;
    logic [CW-1:0]      rd_idx;
    logic signed [31:0] last_rd;
    logic signed [31:0] cond_x;
    logic [31:0]        mag_in;
    logic signed [64:0] cum_wide;
    logic signed [63:0] cum_next;
    logic signed [39:0] win_next;
    logic [31:0]        old_x;
    logic               div_start;
    logic signed [63:0] div_dividend;
    logic [32:0]        div_divisor;
    logic               div_done;
    logic signed [31:0] div_quot;
    logic signed [49:0] ema_sum;
    logic signed [33:0] ema_q;
    logic signed [31:0] ema_avg;
    logic [32:0]        watch_abs;
    logic               term;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [31:0]        ram_wdata;
    logic               in_acc;
    logic               cfg_acc;
    logic [16:0]        a_eff;
    logic               finish;

    always_comb begin
        if (r_wlen == 7'd0) begin
            len = LW'(1);
        end else if (LW'(r_wlen) > LW'(WINDOW_MAX)) begin
            len = LW'(WINDOW_MAX);
        end else begin
            len = LW'(r_wlen);
        end
        slot_eff = (LW'(r_slot) < len) ? LW'(r_slot) : '0;
        slot_inc = (slot_eff + LW'(1) == len) ? '0 : slot_eff + LW'(1);
    end

    assign chi    = CW'(r_ch);
    assign rd_idx = (r_state == S_TERM) ? CW'(r_watch) : chi;
    assign last_rd = r_last[rd_idx];

    assign in_acc  = i_in.valid && i_in.ready;
    assign cfg_acc = i_cfg.valid && i_cfg.ready;
    assign i_in.ready  = (r_state == S_IDLE) && !r_clr;
    assign i_cfg.ready = 1'b1;

    assign mag_in = r_sample[31] ? 32'(-r_sample) : r_sample;

    always_comb begin
        case (r_pre_op)
            mmra_pkg::PRE_ABS: begin
                cond_x = (r_sample == mmra_pkg::S32_MIN) ? mmra_pkg::S32_MAX : $signed(mag_in);
            end
            mmra_pkg::PRE_SQ: begin
                cond_x = (|r_prod[65:47]) ? mmra_pkg::S32_MAX : $signed({1'b0, r_prod[46:16]});
            end
            default: begin
                cond_x = r_sample;
            end
        endcase
    end

    always_comb begin
        cum_wide = 65'(r_cum[chi]) + 65'(r_x);
        if (cum_wide[64] != cum_wide[63]) begin
            cum_next = cum_wide[64] ? $signed({1'b1, 63'd0}) : $signed({1'b0, {63{1'b1}}});
        end else begin
            cum_next = cum_wide[63:0];
        end
    end

    assign win_next = r_wsum[chi] + 40'(r_x) - 40'($signed(old_x));

    // the cycle after S_COND holds the conditioned value, so the sums are
    // taken from r_x: hold the divider start until r_x is loaded
    assign div_start = r_div_go;
    assign div_dividend = (r_avg_type == mmra_pkg::AVG_CUM) ? cum_next : 64'(win_next);
    assign div_divisor  = (r_avg_type == mmra_pkg::AVG_CUM) ? 33'(r_tick) + 33'd1 : 33'(len);

    mmra_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quot     (div_quot)
    );

    assign a_eff   = (r_alpha > mmra_pkg::ALPHA_ONE) ? mmra_pkg::ALPHA_ONE : r_alpha;
    assign ema_sum = r_acc + 50'(r_prod) + 50'sd32768;
    assign ema_q   = ema_sum[49:16];
    assign ema_avg = (ema_q > 34'sh0_7FFF_FFFF) ? mmra_pkg::S32_MAX :
                     (ema_q < -34'sh0_8000_0000) ? mmra_pkg::S32_MIN : ema_q[31:0];

    assign watch_abs = last_rd[31] ? 33'(-33'(last_rd)) : 33'(last_rd);
    assign term      = (32'(r_watch) < 32'(CHANNELS)) && (watch_abs < 33'(r_crit));

    always_comb begin
        if (r_clr) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr_addr;
            ram_wdata = '0;
        end else begin
            ram_we    = r_div_go && (r_avg_type == mmra_pkg::AVG_WIN);
            ram_waddr = r_widx;
            ram_wdata = r_x;
        end
    end

    mmra_ram #(
        .WIDTH (32),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (r_widx),
        .o_rdata (old_x)
    );

    assign finish = (r_state == S_TERM) && (!r_ovalid || o_out.ready);

    always_ff @(posedge i_clk) begin
        r_prod <= r_ma * r_mb;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_avg_type <= mmra_pkg::AVG_CUM;
            r_pre_op   <= mmra_pkg::PRE_PASS;
            r_wlen     <= mmra_pkg::WLEN_RESET;
            r_alpha    <= mmra_pkg::ALPHA_RESET;
            r_crit     <= '0;
            r_watch    <= '0;
            r_tick     <= '0;
            r_slot     <= '0;
            r_clr      <= 1'b1;
            r_clr_addr <= '0;
            r_ovalid   <= 1'b0;
            r_term_done <= 1'b0;
            r_div_go   <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_cum[i]  <= '0;
                r_wsum[i] <= '0;
                r_last[i] <= '0;
            end
        end else begin
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DEPTH - 1)) begin
                    r_clr <= 1'b0;
                end
            end

            if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end

            r_div_go <= (r_state == S_COND) && r_in_rng &&
                        (r_avg_type == mmra_pkg::AVG_CUM || r_avg_type == mmra_pkg::AVG_WIN);

            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_sample <= i_in.sample;
                        r_ch     <= i_in.channel;
                        r_eot    <= i_in.end_of_tick;
                        r_in_rng <= 32'(i_in.channel) < 32'(CHANNELS);
                        r_widx   <= AW'(int'(slot_eff) * CHANNELS + int'(i_in.channel));
                        r_ma     <= 33'(i_in.sample[31] ? 32'(-i_in.sample) : i_in.sample);
                        r_mb     <= 33'(i_in.sample[31] ? 32'(-i_in.sample) : i_in.sample);
                        r_state  <= S_SQ;
                    end
                end
                S_SQ: begin
                    r_state <= S_COND;
                end
                S_COND: begin
                    r_x <= cond_x;
                    r_state <= S_TERM;
                    if (r_in_rng) begin
                        case (r_avg_type)
                            mmra_pkg::AVG_CUM: begin
                                r_state <= S_DIV;
                            end
                            mmra_pkg::AVG_WIN: begin
                                r_state <= S_DIV;
                            end
                            mmra_pkg::AVG_EXP: begin
                                r_ma    <= 33'(mmra_pkg::ALPHA_ONE - a_eff);
                                r_mb    <= 33'(last_rd);
                                r_state <= S_EM1;
                            end
                            default: begin
                                r_avg <= last_rd;
                            end
                        endcase
                    end else begin
                        r_avg <= '0;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_avg        <= div_quot;
                        r_last[chi]  <= div_quot;
                        r_state      <= S_TERM;
                    end
                end
                S_EM1: begin
                    r_ma    <= 33'(a_eff);
                    r_mb    <= 33'(r_x);
                    r_state <= S_EM2;
                end
                S_EM2: begin
                    r_acc   <= 50'(r_prod);
                    r_state <= S_EM3;
                end
                S_EM3: begin
                    r_avg       <= ema_avg;
                    r_last[chi] <= ema_avg;
                    r_state     <= S_TERM;
                end
                S_TERM: begin
                    if (finish) begin
                        r_ovalid    <= 1'b1;
                        r_term_done <= term;
                        r_oavg      <= r_avg;
                        r_och       <= r_ch;
                        r_state     <= S_IDLE;
                        if (r_eot) begin
                            if (r_avg_type == mmra_pkg::AVG_CUM) begin
                                if (r_tick != 32'hFFFF_FFFF) begin
                                    r_tick <= r_tick + 32'd1;
                                end
                            end else if (r_avg_type == mmra_pkg::AVG_WIN) begin
                                r_slot <= SW'(slot_inc);
                            end
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            // cumulative and window sums update on the cycle the divider starts
            if (div_start) begin
                if (r_avg_type == mmra_pkg::AVG_CUM) begin
                    r_cum[chi] <= cum_next;
                end else begin
                    r_wsum[chi] <= win_next;
                end
            end

            if (cfg_acc) begin
                case (i_cfg.index)
                    mmra_pkg::CFG_AVG_TYPE: begin
                        if (i_cfg.data[1:0] != r_avg_type) begin
                            r_tick <= '0;
                            r_slot <= '0;
                        end
                        r_avg_type <= i_cfg.data[1:0];
                    end
                    mmra_pkg::CFG_PRE_OP: begin
                        r_pre_op <= i_cfg.data[1:0];
                    end
                    mmra_pkg::CFG_WINDOW_LEN: begin
                        if (i_cfg.data[6:0] != r_wlen) begin
                            r_tick     <= '0;
                            r_slot     <= '0;
                            r_clr      <= 1'b1;
                            r_clr_addr <= '0;
                            for (int i = 0; i < CHANNELS; i++) begin
                                r_wsum[i] <= '0;
                            end
                        end
                        r_wlen <= i_cfg.data[6:0];
                    end
                    mmra_pkg::CFG_ALPHA: begin
                        r_alpha <= i_cfg.data[16:0];
                    end
                    mmra_pkg::CFG_CRITERION: begin
                        r_crit <= i_cfg.data[30:0];
                    end
                    mmra_pkg::CFG_WATCHED: begin
                        r_watch <= i_cfg.data[3:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out.valid       = r_ovalid;
    assign o_out.average     = r_oavg;
    assign o_out.out_channel = r_och;
    assign o_out.terminate   = r_term_done;
endmodule
`default_nettype wire
